/* design/raster_to_page_bitplane_converter_unit_defines.svh */
// Assertion macros shared by the converter's modules.
`ifndef RASTER_TO_PAGE_BITPLANE_CONVERTER_UNIT_DEFINES_SVH
`define RASTER_TO_PAGE_BITPLANE_CONVERTER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define R2P_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define R2P_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define R2P_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/r2p_pkg.sv */
package r2p_pkg;

  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 64;

  localparam int PAGE_COUNT = (FRAME_HEIGHT + 7) / 8;
  localparam int COL_W      = $clog2(FRAME_WIDTH);
  localparam int ROW_W      = $clog2(FRAME_HEIGHT);
  localparam int PROD_W     = ROW_W + COL_W;
  localparam int DATA_W     = 8;
  localparam int ADDR_W     = 13;

  // Row index inside the bottom page of the frame.
  localparam logic [2:0] LAST_PAGE_K = 3'((FRAME_HEIGHT - 1) % 8);
  localparam logic [2:0] FULL_PAGE_K = 3'd7;

  localparam logic [DATA_W-1:0] LIT_BYTE  = 8'hff;
  localparam logic [DATA_W-1:0] DARK_BYTE = 8'h00;

  localparam logic DIR_PACK   = 1'b0;
  localparam logic DIR_UNPACK = 1'b1;

  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 2;

  typedef struct packed {
    logic              dir;
    logic [DATA_W-1:0] data;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;     // pixel row when packing, first row of the page when unpacking
    logic              emit;    // packing: this row completes a page
    logic [2:0]        last_k;  // unpacking: index of the final row in this page
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } res_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    logic [PROD_W-1:0] p;
    p = PROD_W'(row) * PROD_W'(FRAME_WIDTH) + PROD_W'(col);
    return ADDR_W'(p);
  endfunction

endpackage

/* design/r2p_ram.sv */
module r2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/r2p_front.sv */
module r2p_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_direction,
  input  logic                       push,
  input  logic [r2p_pkg::DATA_W-1:0] data_in,
  input  logic                       cmdq_full,
  output logic                       cmd_push,
  output r2p_pkg::cmd_t              cmd
);
  import r2p_pkg::*;

  logic             dir_r, dir_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] rp_r, rp_nxt;
  logic             accept;
  logic             col_wrap;
  logic             rp_wrap;

  assign accept   = push && !cmdq_full;
  assign col_wrap = (col_r == COL_W'(FRAME_WIDTH - 1));
  assign rp_wrap  = (dir_r == DIR_PACK) ? (rp_r == ROW_W'(FRAME_HEIGHT - 1))
                                        : (rp_r == ROW_W'(PAGE_COUNT - 1));

  always_comb begin
    cmd.dir  = dir_r;
    cmd.data = data_in;
    cmd.col  = col_r;
    if (dir_r == DIR_PACK) begin
      cmd.row    = rp_r;
      cmd.emit   = (rp_r[2:0] == 3'd7) || (rp_r == ROW_W'(FRAME_HEIGHT - 1));
      cmd.last_k = FULL_PAGE_K;
    end else begin
      cmd.row    = rp_r << 3;
      cmd.emit   = 1'b1;
      cmd.last_k = (rp_r == ROW_W'(PAGE_COUNT - 1)) ? LAST_PAGE_K : FULL_PAGE_K;
    end
  end

  assign cmd_push = accept;

  always_comb begin
    dir_nxt = dir_r;
    col_nxt = col_r;
    rp_nxt  = rp_r;
    if (accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        rp_nxt  = rp_wrap ? '0 : rp_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    // A direction write restarts the frame at its top-left corner.
    if (cfg_we) begin
      dir_nxt = cfg_direction;
      col_nxt = '0;
      rp_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_PACK;
      col_r <= '0;
      rp_r  <= '0;
    end else begin
      dir_r <= dir_nxt;
      col_r <= col_nxt;
      rp_r  <= rp_nxt;
    end
  end

endmodule

/* design/r2p_cmdq.sv */
`include "raster_to_page_bitplane_converter_unit_defines.svh"

module r2p_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  r2p_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output r2p_pkg::cmd_t head
);
  import r2p_pkg::*;

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(CMDQ_DEPTH));
  assign valid   = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `R2P_ASSERT_ALWAYS(a_cmdq_count_bound, count_r <= CNT_W'(CMDQ_DEPTH), "command queue overfilled")
  `R2P_ASSERT_SAME(a_cmdq_no_overflow, push, !full, "request pushed into a full command queue")
  `R2P_ASSERT_NEXT(a_cmdq_push_seen, do_push && !do_pop, valid, "pushed request not visible")

endmodule

/* design/r2p_back.sv */
`include "raster_to_page_bitplane_converter_unit_defines.svh"

module r2p_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  input  r2p_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [r2p_pkg::DATA_W-1:0] out_data,
  output logic [r2p_pkg::ADDR_W-1:0] out_addr,
  output logic                       out_last
);
  import r2p_pkg::*;

  localparam int OPTR_W = $clog2(OUTQ_DEPTH);
  localparam int OCNT_W = $clog2(OUTQ_DEPTH + 1);

  logic              s1_v_r, s1_v_nxt;
  cmd_t              s1_cmd_r;
  logic [2:0]        k_r, k_nxt;

  logic [DATA_W-1:0] acc_rdata;
  logic [DATA_W-1:0] acc;
  logic [2:0]        bit_sel;
  logic              res_v;
  logic              done;
  logic              fire;
  logic              retire;
  logic              load;
  logic [ROW_W-1:0]  arow;
  res_t              res;

  res_t              oq_r [OUTQ_DEPTH];
  logic [OPTR_W-1:0] owr_r, owr_nxt;
  logic [OPTR_W-1:0] ord_r, ord_nxt;
  logic [OCNT_W-1:0] ocnt_r, ocnt_nxt;
  logic              oq_full;
  logic              oq_push;
  logic              oq_pop;

  r2p_ram #(
    .WIDTH(DATA_W),
    .DEPTH(FRAME_WIDTH)
  ) u_acc_ram (
    .clk  (clk),
    .we   (fire && (s1_cmd_r.dir == DIR_PACK)),
    .waddr(s1_cmd_r.col),
    .wdata(acc),
    .re   (load),
    .raddr(cmd.col),
    .rdata(acc_rdata)
  );

  assign bit_sel = s1_cmd_r.row[2:0];

  // The top row of a page starts a fresh column byte.
  always_comb begin
    acc = (bit_sel == 3'd0) ? '0 : acc_rdata;
    if (s1_cmd_r.data != '0) begin
      acc = acc | (DATA_W'(1) << bit_sel);
    end
  end

  always_comb begin
    if (s1_cmd_r.dir == DIR_PACK) begin
      res_v = s1_cmd_r.emit;
      done  = 1'b1;
      arow  = s1_cmd_r.row >> 3;
    end else begin
      res_v = 1'b1;
      done  = (k_r == s1_cmd_r.last_k);
      arow  = s1_cmd_r.row + ROW_W'(k_r);
    end
  end

  always_comb begin
    res.addr = addr_of(arow, s1_cmd_r.col);
    res.last = done;
    if (s1_cmd_r.dir == DIR_PACK) begin
      res.data = acc;
    end else begin
      res.data = s1_cmd_r.data[k_r] ? LIT_BYTE : DARK_BYTE;
    end
  end

  assign fire    = s1_v_r && (!res_v || !oq_full);
  assign retire  = fire && done;
  assign load    = cmd_valid && (!s1_v_r || retire);
  assign cmd_pop = load;
  assign oq_push = fire && res_v;

  always_comb begin
    s1_v_nxt = s1_v_r;
    k_nxt    = k_r;
    if (load) begin
      s1_v_nxt = 1'b1;
      k_nxt    = '0;
    end else if (retire) begin
      s1_v_nxt = 1'b0;
    end else if (fire) begin
      k_nxt = k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_cmd_r <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      k_r    <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      k_r    <= k_nxt;
    end
  end

  // Result queue: decouples the result side so a stalled pop does not block a new request until it fills.
  assign oq_full   = (ocnt_r == OCNT_W'(OUTQ_DEPTH));
  assign out_empty = (ocnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;
  assign out_data  = oq_r[ord_r].data;
  assign out_addr  = oq_r[ord_r].addr;
  assign out_last  = oq_r[ord_r].last;

  always_comb begin
    owr_nxt  = owr_r;
    ord_nxt  = ord_r;
    ocnt_nxt = ocnt_r;
    if (oq_push) begin
      owr_nxt = (owr_r == OPTR_W'(OUTQ_DEPTH - 1)) ? '0 : owr_r + 1'b1;
    end
    if (oq_pop) begin
      ord_nxt = (ord_r == OPTR_W'(OUTQ_DEPTH - 1)) ? '0 : ord_r + 1'b1;
    end
    if (oq_push && !oq_pop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (oq_pop && !oq_push) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[owr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owr_r  <= owr_nxt;
      ord_r  <= ord_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  `R2P_ASSERT_SAME(a_k_in_page, s1_v_r && (s1_cmd_r.dir == DIR_UNPACK), k_r <= s1_cmd_r.last_k, "row index ran past the page")
  `R2P_ASSERT_NEXT(a_hold_mid_page, fire && !done, s1_v_r && $stable(s1_cmd_r), "request left the stage before its last row")
  `R2P_ASSERT_ALWAYS(a_outq_bound, ocnt_r <= OCNT_W'(OUTQ_DEPTH), "result queue overfilled")

endmodule

/* design/raster_to_page_bitplane_converter_unit.sv */
// Raster / page layout converter for a monochrome frame.
// Input channel: in_push with in_data_in; a request is taken when in_push is high
// and in_full is low. Result channel: while out_empty is low the oldest result sits
// on out_data_out, out_address and out_last, and out_pop takes it.
// cfg_we writes cfg_direction (0 packs raster pixel bytes into page column bytes,
// 1 unpacks page bytes into pixel bytes) and restarts the frame at the top-left.
// Write it only while no request is in flight.
// A front stage tracks column and row or page and tags each request, a four-entry
// queue holds tagged requests, and a back stage updates the column accumulator RAM
// or expands a page byte into pixels, feeding a two-entry result queue.
// A taken request passes through the command queue and the back stage register.
// Throughput: packing takes one pixel per cycle and unpacking gives one result per
// cycle, either unless a full result queue stalls the back stage; a page byte
// occupies the back stage for up to eight results, set by the single result port.
// Reset clears the direction, counters and queues; accumulator contents are rebuilt
// at the top row of every page. When the receiver stalls, results back up into the
// queues and in_full rises once both are full.
module raster_to_page_bitplane_converter_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_direction,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [r2p_pkg::DATA_W-1:0] in_data_in,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [r2p_pkg::DATA_W-1:0] out_data_out,
  output logic [r2p_pkg::ADDR_W-1:0] out_address,
  output logic                       out_last
);
  import r2p_pkg::*;

  logic cmd_push;
  cmd_t cmd_in;
  logic cmdq_full;
  logic cmdq_valid;
  logic cmdq_pop;
  cmd_t cmdq_head;

  assign in_full = cmdq_full;

  r2p_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_direction(cfg_direction),
    .push         (in_push),
    .data_in      (in_data_in),
    .cmdq_full    (cmdq_full),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  r2p_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd_in),
    .full     (cmdq_full),
    .pop      (cmdq_pop),
    .valid    (cmdq_valid),
    .head     (cmdq_head)
  );

  r2p_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmdq_valid),
    .cmd      (cmdq_head),
    .cmd_pop  (cmdq_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data_out),
    .out_addr (out_address),
    .out_last (out_last)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import r2p_pkg::*;

  localparam int SETTLE_CYCLES        = 20;
  localparam int MAX_REPORTS          = 10;
  localparam int IDLE_PERCENT         = 28;
  localparam int STEADY_FROM          = 1000;
  localparam int STEADY_TO            = 1600;
  localparam int HOLD_CYCLES          = 300;
  localparam int DIRECTED_ITEMS       = 13;
  localparam int HOLD_AT_ITEM         = DIRECTED_ITEMS + 40;
  localparam int UNPACK_ITEMS         = FRAME_WIDTH + 32;
  localparam int PACK_PART_ITEMS      = 60;
  localparam int UNPACK_RESTART_ITEMS = 40;
  localparam int UNPACK_AGAIN_ITEMS   = 30;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } frame_write_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_direction = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic [DATA_W-1:0] in_data_in = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [DATA_W-1:0] out_data_out;
  logic [ADDR_W-1:0] out_address;
  logic              out_last;

  raster_to_page_bitplane_converter_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_direction(cfg_direction),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data_in   (in_data_in),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_data_out (out_data_out),
    .out_address  (out_address),
    .out_last     (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the converter's state.
  logic              cur_dir;
  int                col_count;
  int                row_count;
  logic [DATA_W-1:0] col_acc [FRAME_WIDTH];

  logic [DATA_W-1:0] items_to_send [$];
  frame_write_t      frame_writes_due [$];

  int cycle_no;
  int accepted_total;
  int results_checked;
  int mismatches;
  int hold_left;
  bit hold_done;

  wire steady = (cycle_no >= STEADY_FROM) && (cycle_no < STEADY_TO);

  // Works out the frame writes that one accepted request causes.
  task automatic convert_item(input logic [DATA_W-1:0] byte_in);
    int                bit_k;
    int                row;
    int                last_k;
    int                span;
    int                addr;
    int                k;
    logic [DATA_W-1:0] col_byte;
    frame_write_t      w;
    if (cur_dir == DIR_PACK) begin
      bit_k = row_count % 8;
      col_byte = (bit_k == 0) ? '0 : col_acc[col_count];
      if (byte_in != '0) col_byte[bit_k] = 1'b1;
      col_acc[col_count] = col_byte;
      if (bit_k == 7 || row_count == FRAME_HEIGHT - 1) begin
        addr = (row_count / 8) * FRAME_WIDTH + col_count;
        w.data = col_byte;
        w.addr = addr[ADDR_W-1:0];
        w.last = 1'b1;
        frame_writes_due.push_back(w);
      end
      span = FRAME_HEIGHT;
    end else begin
      last_k = FRAME_HEIGHT - 1 - row_count * 8;
      if (last_k > 7) last_k = 7;
      for (k = 0; k <= last_k; k++) begin
        row = row_count * 8 + k;
        addr = row * FRAME_WIDTH + col_count;
        w.data = byte_in[k] ? LIT_BYTE : DARK_BYTE;
        w.addr = addr[ADDR_W-1:0];
        w.last = (k == last_k);
        frame_writes_due.push_back(w);
      end
      span = PAGE_COUNT;
    end
    col_count++;
    if (col_count >= FRAME_WIDTH) begin
      col_count = 0;
      row_count++;
      if (row_count >= span) row_count = 0;
    end
  endtask

  task automatic log_mismatch(input string why, input frame_write_t want,
                              input frame_write_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %0d (%s): expected data=%02h addr=%0d last=%0b, got data=%02h addr=%0d last=%0b",
               mismatches, why, want.data, want.addr, want.last,
               got.data, got.addr, got.last);
  endtask

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // Driver: holds a request while in_full is high, otherwise takes the next one or idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        convert_item(in_data_in);
        accepted_total++;
      end
      if (!(in_push && in_full)) begin
        if (items_to_send.size() != 0 &&
            (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          in_push    <= 1'b1;
          in_data_in <= items_to_send.pop_front();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering page bytes.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_total >= HOLD_AT_ITEM) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks every popped result against the oldest expected frame write.
  always @(posedge clk) begin
    frame_write_t got;
    frame_write_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        got.data = out_data_out;
        got.addr = out_address;
        got.last = out_last;
        results_checked++;
        if (frame_writes_due.size() == 0) begin
          log_mismatch("no result expected", '0, got);
        end else begin
          want = frame_writes_due.pop_front();
          if (got.data !== want.data || got.addr !== want.addr || got.last !== want.last)
            log_mismatch("field differs", want, got);
        end
      end
      out_pop <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (items_to_send.size() != 0 || in_push || frame_writes_due.size() != 0)
      @(negedge clk);
    // Pixel requests that finish no page leave no trace, so let the pipeline empty.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic dir_value);
    wait_drained();
    cfg_we        <= 1'b1;
    cfg_direction <= dir_value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_dir   = dir_value;
    col_count = 0;
    row_count = 0;
  endtask

  function automatic logic [DATA_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return '0;
      5:             return 8'hff;
      6:             return 8'h01;
      default:       return DATA_W'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] random_page();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return DATA_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    cur_dir   = DIR_PACK;
    col_count = 0;
    row_count = 0;
    foreach (col_acc[i]) col_acc[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: page bytes with every bit position, then pixels that finish no page.
    write_direction(DIR_UNPACK);
    items_to_send.push_back(8'h00);
    items_to_send.push_back(8'hff);
    items_to_send.push_back(8'h01);
    items_to_send.push_back(8'h80);
    items_to_send.push_back(8'h55);
    items_to_send.push_back(8'haa);
    items_to_send.push_back(8'h7e);
    write_direction(DIR_PACK);
    items_to_send.push_back(8'h00);
    items_to_send.push_back(8'hff);
    items_to_send.push_back(8'h01);
    items_to_send.push_back(8'h80);
    items_to_send.push_back(8'h7f);
    items_to_send.push_back(8'h00);

    // More than one page of page bytes, so the column count wraps into the next page.
    write_direction(DIR_UNPACK);
    repeat (UNPACK_ITEMS) items_to_send.push_back(random_page());

    // Switch direction in the middle of a row, then restart unpacking mid-page.
    write_direction(DIR_PACK);
    repeat (PACK_PART_ITEMS) items_to_send.push_back(random_pixel());
    write_direction(DIR_UNPACK);
    repeat (UNPACK_RESTART_ITEMS) items_to_send.push_back(random_page());
    write_direction(DIR_UNPACK);
    repeat (UNPACK_AGAIN_ITEMS) items_to_send.push_back(random_page());

    wait_drained();
    $display("Sent %0d requests through packing and unpacking, with a page wrap, a long",
             accepted_total);
    $display("receiver stall and mid-frame direction changes; %0d results checked, %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0 && frame_writes_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
